// ----- sv/fcf_pkg.sv -----
package fcf_pkg;

    localparam int KERNEL_LEN = 16;
    localparam int SAMPLE_W   = 16;
    localparam int TAP_IDX_W  = 4;
    localparam int ACTION_W   = 2;

    // Position in the frame counts up to KERNEL_LEN and holds there.
    localparam int POS_W  = $clog2(KERNEL_LEN + 1);
    localparam int CNT_W  = $clog2(KERNEL_LEN);
    // Crossfaded tap numerator: |n*cur + (K-n)*prev| <= K * 2^15.
    localparam int NUM_W  = SAMPLE_W + $clog2(KERNEL_LEN);
    localparam int PROD_W = NUM_W + SAMPLE_W;
    localparam int ACC_W  = PROD_W + $clog2(KERNEL_LEN);
    localparam int P_W    = ACC_W + SAMPLE_W;
    localparam int LO_W   = ACC_W / 2;
    // Scale of K * 2^26 taken as a shift; KERNEL_LEN must be a power of two.
    localparam int DIV_SH = $clog2(KERNEL_LEN) + 26;
    localparam int Q_W    = P_W - DIV_SH;

    localparam logic [ACTION_W-1:0] ACT_TAP    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GAIN   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] UNITY_TAP  = 16'sd16384;
    localparam logic signed [SAMPLE_W-1:0] UNITY_GAIN = 16'sd4096;

    localparam logic signed [P_W-1:0] ROUND_HALF =
        {{(P_W - DIV_SH){1'b0}}, 1'b1, {(DIV_SH - 1){1'b0}}};
    localparam logic signed [Q_W-1:0] Q_MAX =
        {{(Q_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN =
        {{(Q_W - SAMPLE_W + 1){1'b1}}, {(SAMPLE_W - 1){1'b0}}};

    // Contents of one cell, handed to the neighbor while rotating.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] cur;
        logic signed [SAMPLE_W-1:0] prev;
        logic signed [SAMPLE_W-1:0] x;
    } t_tap;

    typedef struct packed {
        logic shift;
        logic rotate;
        logic load;
        logic commit;
    } t_cell_ctl;

    typedef struct packed {
        logic clear;
        logic feed;
        logic lo;
        logic hi;
    } t_mac_ctl;

endpackage

// ----- sv/fcf_cell.sv -----
module fcf_cell
    import fcf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_ctl                  i_ctl,
    input  logic                       i_sel,
    input  logic                       i_first,
    input  logic signed [SAMPLE_W-1:0] i_value,
    input  logic signed [SAMPLE_W-1:0] i_xin,
    input  t_tap                       i_left,
    output t_tap                       o_tap
);

    logic signed [SAMPLE_W-1:0] r_cur;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [SAMPLE_W-1:0] r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= i_first ? UNITY_TAP : '0;
            r_prev <= i_first ? UNITY_TAP : '0;
            r_x    <= '0;
        end else if (i_ctl.rotate) begin
            r_cur  <= i_left.cur;
            r_prev <= i_left.prev;
            r_x    <= i_left.x;
        end else begin
            if (i_ctl.shift) begin
                r_x <= i_xin;
            end
            if (i_ctl.load && i_sel) begin
                r_cur <= i_value;
            end
            if (i_ctl.commit) begin
                r_prev <= r_cur;
            end
        end
    end

    assign o_tap.cur  = r_cur;
    assign o_tap.prev = r_prev;
    assign o_tap.x    = r_x;

endmodule

// ----- sv/fcf_mac.sv -----
module fcf_mac
    import fcf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_ctl                   i_ctl,
    input  t_tap                       i_tap,
    input  logic [POS_W-1:0]           i_pos,
    input  logic signed [SAMPLE_W-1:0] i_gain,
    output logic                       o_busy,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_sat
);

    logic signed [NUM_W-1:0]  w_pos_x;
    logic signed [NUM_W-1:0]  w_rem_x;
    logic signed [NUM_W-1:0]  w_cur_x;
    logic signed [NUM_W-1:0]  w_prev_x;
    logic signed [NUM_W-1:0]  w_num;
    logic [POS_W-1:0]         w_rem;

    logic signed [NUM_W-1:0]    r_num;
    logic signed [SAMPLE_W-1:0] r_x1;
    logic                       r_v1;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_v2;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [P_W-1:0]      r_pp;
    logic signed [P_W-1:0]      r_p;

    logic signed [PROD_W-1:0] w_num_x;
    logic signed [PROD_W-1:0] w_x_x;
    logic signed [P_W-1:0]    w_lo_x;
    logic signed [P_W-1:0]    w_hi_x;
    logic signed [P_W-1:0]    w_gain_x;
    logic signed [P_W-1:0]    w_round;
    logic signed [Q_W-1:0]    w_q;

    // Weight numerator n*cur + (K-n)*prev; at n == K this is K*cur.
    assign w_rem    = POS_W'(KERNEL_LEN) - i_pos;
    assign w_pos_x  = NUM_W'(signed'({1'b0, i_pos}));
    assign w_rem_x  = NUM_W'(signed'({1'b0, w_rem}));
    assign w_cur_x  = NUM_W'(i_tap.cur);
    assign w_prev_x = NUM_W'(i_tap.prev);
    assign w_num    = w_pos_x * w_cur_x + w_rem_x * w_prev_x;

    assign w_num_x  = PROD_W'(r_num);
    assign w_x_x    = PROD_W'(r_x1);

    // The gain product is split into a low and a high half of the sum.
    assign w_lo_x   = P_W'(signed'({1'b0, r_acc[LO_W-1:0]}));
    assign w_hi_x   = P_W'(signed'(r_acc[ACC_W-1:LO_W]));
    assign w_gain_x = P_W'(i_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.feed;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.feed) begin
            r_num <= w_num;
            r_x1  <= i_tap.x;
        end
        if (r_v1) begin
            r_prod <= w_num_x * w_x_x;
        end
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_ctl.lo) begin
            r_pp <= w_lo_x * w_gain_x;
        end
        if (i_ctl.hi) begin
            r_p <= ((w_hi_x * w_gain_x) <<< LO_W) + r_pp;
        end
    end

    // Round half up, then floor through the arithmetic shift.
    assign w_round = r_p + ROUND_HALF;
    assign w_q     = signed'(w_round[P_W-1:DIV_SH]);

    always_comb begin
        if (w_q > Q_MAX) begin
            o_sample = Q_MAX[SAMPLE_W-1:0];
            o_sat    = 1'b1;
        end else if (w_q < Q_MIN) begin
            o_sample = Q_MIN[SAMPLE_W-1:0];
            o_sat    = 1'b1;
        end else begin
            o_sample = w_q[SAMPLE_W-1:0];
            o_sat    = 1'b0;
        end
    end

    assign o_busy = r_v1 | r_v2;

endmodule

// ----- sv/crossfaded_fir_filter.sv -----
// Tap and gain loads do not stall the input; a new word is accepted every cycle
// while the block is idle. A sample runs KERNEL_LEN rotations of the cell ring
// through the shared multiply-accumulate, then a pipeline drain, the gain
// multiply in low and high halves, rounding and the output register load, which
// waits while the output is stalled. Synchronous active-low reset loads tap 0 with 1.0,
// the other taps and the history with zero, the gain with 1.0.
module crossfaded_fir_filter
    import fcf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [ACTION_W-1:0]        i_action,
    input  logic [TAP_IDX_W-1:0]       i_tap_index,
    input  logic signed [SAMPLE_W-1:0] i_value,
    input  logic                       i_last_in_frame,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_saturated
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROT  = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_HI   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    logic [CNT_W-1:0]           r_cnt;
    logic [POS_W-1:0]           r_pos;
    logic signed [SAMPLE_W-1:0] r_gain;
    logic                       r_last;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_sat;

    logic                       w_accept;
    logic                       w_out_load;
    logic                       w_mac_busy;
    logic signed [SAMPLE_W-1:0] w_mac_sample;
    logic                       w_mac_sat;
    t_cell_ctl                  w_cell_ctl;
    t_mac_ctl                   w_mac_ctl;
    t_tap                       w_tap [KERNEL_LEN];
    logic signed [SAMPLE_W-1:0] w_xin [KERNEL_LEN];
    logic [KERNEL_LEN-1:0]      w_sel;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    assign w_cell_ctl.shift  = w_accept && (i_action == ACT_SAMPLE);
    assign w_cell_ctl.load   = w_accept && (i_action == ACT_TAP);
    assign w_cell_ctl.rotate = (r_state == S_ROT);
    assign w_cell_ctl.commit = w_out_load && r_last;

    assign w_mac_ctl.clear = w_cell_ctl.shift;
    assign w_mac_ctl.feed  = (r_state == S_ROT);
    assign w_mac_ctl.lo    = (r_state == S_WAIT) && !w_mac_busy;
    assign w_mac_ctl.hi    = (r_state == S_HI);

    // Ring of cells: each hands its taps and sample to the next one while
    // rotating, and the last cell feeds the multiply-accumulate unit.
    for (genvar k = 0; k < KERNEL_LEN; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_xin[k] = i_value;
        end else begin : g_body
            assign w_xin[k] = w_tap[k-1].x;
        end

        if (k < (1 << TAP_IDX_W)) begin : g_addr
            assign w_sel[k] = (i_tap_index == TAP_IDX_W'(k));
        end else begin : g_noaddr
            assign w_sel[k] = 1'b0;
        end

        fcf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_cell_ctl),
            .i_sel   (w_sel[k]),
            .i_first (k == 0),
            .i_value (i_value),
            .i_xin   (w_xin[k]),
            .i_left  (w_tap[(k + KERNEL_LEN - 1) % KERNEL_LEN]),
            .o_tap   (w_tap[k])
        );
    end

    fcf_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_tap    (w_tap[KERNEL_LEN-1]),
        .i_pos    (r_pos),
        .i_gain   (r_gain),
        .o_busy   (w_mac_busy),
        .o_sample (w_mac_sample),
        .o_sat    (w_mac_sat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_cell_ctl.shift) begin
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                if (r_cnt == CNT_W'(KERNEL_LEN - 1)) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!w_mac_busy) begin
                    n_state = S_HI;
                end
            end
            S_HI: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_gain      <= UNITY_GAIN;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cell_ctl.shift) begin
                r_cnt  <= '0;
                r_last <= i_last_in_frame;
            end else if (r_state == S_ROT) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (w_accept && (i_action == ACT_GAIN)) begin
                r_gain <= i_value;
            end
            if (w_out_load) begin
                if (r_last) begin
                    r_pos <= '0;
                end else if (r_pos < POS_W'(KERNEL_LEN)) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_sample <= w_mac_sample;
            r_sat    <= w_mac_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample;
    assign o_saturated  = r_sat;

    a_idle_not_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_mac_busy)
        else $error("accumulator pipeline active while idle");

    a_sample_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell_ctl.shift |=> (r_state == S_ROT) && (r_cnt == '0))
        else $error("sample word did not start a rotation sweep");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_out_valid && i_out_stall)
        |=> (r_state == S_OUT) && r_out_valid)
        else $error("pending result overwritten");

    a_pos_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(KERNEL_LEN))
        else $error("frame position beyond kernel length");

endmodule

// ----- tb/sv/crossfaded_fir_filter_tb.sv -----
module crossfaded_fir_filter_tb;
    import fcf_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int FRAC_SHIFT  = $clog2(KERNEL_LEN) + 26;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_WORDS = 430;

    typedef struct packed {
        logic [ACTION_W-1:0]        action;
        logic [TAP_IDX_W-1:0]       tap;
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } t_fir_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sat;
    } t_filtered;

    class fir_scoreboard;
        logic signed [SAMPLE_W-1:0] cur_taps  [KERNEL_LEN];
        logic signed [SAMPLE_W-1:0] prev_taps [KERNEL_LEN];
        logic signed [SAMPLE_W-1:0] history   [KERNEL_LEN-1];
        logic signed [SAMPLE_W-1:0] gain;
        int        frame_pos;
        t_filtered expected_q[$];
        int        fail_count;

        function new();
            for (int k = 0; k < KERNEL_LEN; k++) begin
                cur_taps[k]  = '0;
                prev_taps[k] = '0;
            end
            for (int k = 0; k < KERNEL_LEN - 1; k++) begin
                history[k] = '0;
            end
            cur_taps[0]  = UNITY_TAP;
            prev_taps[0] = UNITY_TAP;
            gain         = UNITY_GAIN;
            frame_pos    = 0;
            fail_count   = 0;
        endfunction

        function void note_word(t_fir_word w);
            longint    acc;
            longint    weight;
            longint    x;
            longint    q;
            t_filtered res;
            if (w.action == ACT_TAP) begin
                if (int'(w.tap) < KERNEL_LEN) cur_taps[w.tap] = w.value;
            end else if (w.action == ACT_GAIN) begin
                gain = w.value;
            end else if (w.action == ACT_SAMPLE) begin
                acc = 0;
                for (int k = 0; k < KERNEL_LEN; k++) begin
                    // The tap weight slides from the old kernel to the new one over
                    // the first KERNEL_LEN samples of a frame.
                    if (frame_pos < KERNEL_LEN)
                        weight = longint'(frame_pos) * longint'(cur_taps[k])
                               + longint'(KERNEL_LEN - frame_pos) * longint'(prev_taps[k]);
                    else
                        weight = longint'(KERNEL_LEN) * longint'(cur_taps[k]);
                    if (k == 0) x = longint'(w.value);
                    else x = longint'(history[k-1]);
                    acc += weight * x;
                end
                q = (acc * longint'(gain) + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
                res.sat = 1'b0;
                if (q > 32767) begin
                    q = 32767;
                    res.sat = 1'b1;
                end else if (q < -32768) begin
                    q = -32768;
                    res.sat = 1'b1;
                end
                res.sample = q[SAMPLE_W-1:0];
                expected_q.push_back(res);
                for (int k = KERNEL_LEN - 2; k > 0; k--) begin
                    history[k] = history[k-1];
                end
                history[0] = w.value;
                if (w.last) begin
                    for (int k = 0; k < KERNEL_LEN; k++) begin
                        prev_taps[k] = cur_taps[k];
                    end
                    frame_pos = 0;
                end else if (frame_pos < KERNEL_LEN) begin
                    frame_pos++;
                end
            end
        endfunction

        task report(string msg);
            fail_count++;
            if (fail_count <= 40) $display("%0t: ERROR %s", $time, msg);
        endtask

        task check_result(logic signed [SAMPLE_W-1:0] sample, logic sat);
            t_filtered want;
            if (expected_q.size() == 0) begin
                report($sformatf("output word %0d with nothing expected", sample));
                return;
            end
            want = expected_q.pop_front();
            if (sample !== want.sample)
                report($sformatf("sample_out %0d, expected %0d", sample, want.sample));
            if (sat !== want.sat)
                report($sformatf("saturated %0b, expected %0b", sat, want.sat));
        endtask
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [ACTION_W-1:0]        i_action;
    logic [TAP_IDX_W-1:0]       i_tap_index;
    logic signed [SAMPLE_W-1:0] i_value;
    logic                       i_last_in_frame;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       o_saturated;

    fir_scoreboard sb = new();
    int words_sent   = 0;
    bit hold_request = 1'b0;
    bit quiet        = 1'b0;

    crossfaded_fir_filter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_tap_index     (i_tap_index),
        .i_value         (i_value),
        .i_last_in_frame (i_last_in_frame),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sample_out    (o_sample_out),
        .o_saturated     (o_saturated)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_fir_word make_word(logic [ACTION_W-1:0] action, int tap,
                                            logic signed [SAMPLE_W-1:0] value, bit last);
        t_fir_word w;
        w.action = action;
        w.tap    = tap[TAP_IDX_W-1:0];
        w.value  = value;
        w.last   = last;
        return w;
    endfunction

    // A span of zero gives the full 16-bit range, otherwise -span..span-1.
    function automatic logic signed [SAMPLE_W-1:0] rand_val(int span);
        int t;
        if (span == 0) return SAMPLE_W'($urandom);
        t = int'($urandom_range(0, 2 * span - 1)) - span;
        return t[SAMPLE_W-1:0];
    endfunction

    task automatic send_word(t_fir_word w);
        if (!quiet && $urandom_range(0, 6) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= w.action;
        i_tap_index     <= w.tap;
        i_value         <= w.value;
        i_last_in_frame <= w.last;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_word(w);
        if (w.action != ACT_UNUSED) begin
            words_sent++;
            if (words_sent == 150) hold_request = 1'b1;
            if (words_sent >= 400) quiet = 1'b1;
        end
        @(negedge i_clk);
    endtask

    task automatic send_random_frame();
        int len;
        if ($urandom_range(0, 9) == 0)
            send_word(make_word(ACT_UNUSED, $urandom_range(0, 15), rand_val(0),
                                1'($urandom_range(0, 1))));
        repeat ($urandom_range(0, 4))
            send_word(make_word(ACT_TAP, $urandom_range(0, 15),
                                rand_val($urandom_range(0, 3) == 0 ? 0 : 4096),
                                1'($urandom_range(0, 1))));
        if ($urandom_range(0, 3) == 0)
            send_word(make_word(ACT_GAIN, $urandom_range(0, 15),
                                rand_val($urandom_range(0, 3) == 0 ? 0 : 8192),
                                1'($urandom_range(0, 1))));
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_word(make_word(ACT_TAP, $urandom_range(0, 15), rand_val(4096),
                                    1'($urandom_range(0, 1))));
            // Most frames close with a last word; a few run on into the next.
            send_word(make_word(ACT_SAMPLE, $urandom_range(0, 15),
                                rand_val($urandom_range(0, 4) == 0 ? 0 : 8192),
                                (i == len - 1) && ($urandom_range(0, 5) != 0)));
        end
    endtask

    // Result side: random stall bursts, and one long hold-off that backs up the input.
    initial begin
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_result(o_sample_out, o_saturated);
    end

    initial begin
        #2000000;
        $display("crossfaded_fir_filter: mismatch");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_action        = ACT_TAP;
        i_tap_index     = '0;
        i_value         = '0;
        i_last_in_frame = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset kernel passes samples straight through.
        send_word(make_word(ACT_SAMPLE, 0, 16'sh7fff, 1'b0));
        send_word(make_word(ACT_SAMPLE, 15, -16'sh8000, 1'b0));
        send_word(make_word(ACT_SAMPLE, 5, 16'sd12345, 1'b1));
        send_word(make_word(ACT_UNUSED, 9, 16'sh5a5a, 1'b1));
        // Largest gain drives both rails; the last flag on a load does nothing.
        send_word(make_word(ACT_GAIN, 0, 16'sh7fff, 1'b1));
        send_word(make_word(ACT_SAMPLE, 0, 16'sh7fff, 1'b0));
        send_word(make_word(ACT_SAMPLE, 0, -16'sh8000, 1'b0));
        send_word(make_word(ACT_TAP, 15, -16'sh8000, 1'b0));
        send_word(make_word(ACT_TAP, 0, 16'sh7fff, 1'b1));
        send_word(make_word(ACT_TAP, 7, 16'sd12, 1'b0));
        // Short frames: history must carry over the frame boundaries.
        send_word(make_word(ACT_SAMPLE, 3, 16'sd1000, 1'b1));
        send_word(make_word(ACT_GAIN, 0, -16'sh8000, 1'b0));
        send_word(make_word(ACT_SAMPLE, 0, 16'sd20000, 1'b0));
        send_word(make_word(ACT_SAMPLE, 0, -16'sd1, 1'b1));
        send_word(make_word(ACT_GAIN, 0, UNITY_GAIN, 1'b0));
        send_word(make_word(ACT_SAMPLE, 10, 16'sd300, 1'b0));
        // A tap load inside a frame applies from the next sample on.
        send_word(make_word(ACT_TAP, 3, 16'sd8192, 1'b0));
        send_word(make_word(ACT_SAMPLE, 0, -16'sd4000, 1'b0));
        send_word(make_word(ACT_TAP, 15, 16'sh7fff, 1'b0));
        send_word(make_word(ACT_SAMPLE, 15, 16'sd7, 1'b1));
        send_word(make_word(ACT_SAMPLE, 0, 16'sd2222, 1'b1));
        send_word(make_word(ACT_SAMPLE, 0, -16'sd2222, 1'b1));

        while (words_sent < RANDOM_WORDS) send_random_frame();
        i_in_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (KERNEL_LEN + 10) @(posedge i_clk);
        if (sb.fail_count == 0)
            $display("crossfaded_fir_filter: match");
        else
            $display("crossfaded_fir_filter: mismatch");
        $finish;
    end

endmodule
